@@ rtl/core/vsll_pkg.sv @@
`default_nettype none

package vsll_pkg;

  localparam int ADC_W = 12;
  localparam int REQ_W = 7;
  localparam int MV_W = 16;
  localparam int CC_W = 8;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ADC_FULL_SCALE = 4095;

  localparam logic [1:0] CLASS_LOW = 2'd0;
  localparam logic [1:0] CLASS_HIGH = 2'd1;
  localparam logic [1:0] CLASS_BAND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CEILING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_CYCLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_DOWN_INIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_UP_LOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_UP_HIGH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NO_NOMINAL = 3'd7;

  localparam logic [MV_W-1:0] RST_LOW_THRESHOLD = 16'd11000;
  localparam logic [MV_W-1:0] RST_HIGH_THRESHOLD = 16'd13000;
  localparam logic [REQ_W-1:0] RST_LIMIT_CEILING = 7'd10;
  localparam logic [CC_W-1:0] RST_CONFIRM_CYCLES = 8'd4;
  localparam logic [CNT_W-1:0] RST_PAUSE_DOWN_INIT = 16'd10;
  localparam logic [CNT_W-1:0] RST_PAUSE_UP_LOW = 16'd50;
  localparam logic [CNT_W-1:0] RST_PAUSE_UP_HIGH = 16'd20;
  localparam logic [CNT_W-1:0] RST_MAX_NO_NOMINAL = 16'd1000;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic [REQ_W-1:0] required_step;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0]  filtered_mv;
    logic [1:0]       level_class;
    logic [REQ_W-1:0] curr_limit;
    logic             limit_moved;
    logic             no_nominal_error;
    logic [CNT_W-1:0] error_total;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0]  low_threshold_mv;
    logic [MV_W-1:0]  high_threshold_mv;
    logic [REQ_W-1:0] limit_ceiling;
    logic [CC_W-1:0]  confirm_cycles;
    logic [CNT_W-1:0] pause_down_init;
    logic [CNT_W-1:0] pause_up_after_low;
    logic [CNT_W-1:0] pause_up_after_high;
    logic [CNT_W-1:0] max_no_nominal;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       level_class;
    logic [REQ_W-1:0] curr_limit;
    logic             limit_moved;
    logic             no_nominal_error;
    logic [CNT_W-1:0] error_total;
  } lvl_res_t;

endpackage

`default_nettype wire

@@ rtl/core/vsll_mul.sv @@
`default_nettype none

module vsll_mul #(
  parameter int A_W = 25,
  parameter int B_W = 21
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

@@ rtl/core/vsll_ring.sv @@
`default_nettype none

module vsll_ring #(
  parameter int AVG_DEPTH = 16,
  parameter int SUM_W = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr,
  input  wire logic [vsll_pkg::ADC_W-1:0]  sample,
  output logic      [SUM_W-1:0]            sum
);

  import vsll_pkg::*;

  localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  logic [ADC_W-1:0] mem [AVG_DEPTH];
  logic [ADC_W-1:0] rdata;
  logic [ADC_W-1:0] old_sample;
  logic [PTR_W-1:0] ptr;
  logic             wrapped;

  // Entries are written in pointer order, so an entry holds data once the pointer has wrapped.
  assign old_sample = wrapped ? rdata : '0;

  always_ff @(posedge clk) begin
    rdata <= mem[ptr];
    if (wr) begin
      mem[ptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      wrapped <= 1'b0;
      sum <= '0;
    end else if (wr) begin
      sum <= sum - SUM_W'(old_sample) + SUM_W'(sample);
      if (ptr == PTR_W'(AVG_DEPTH - 1)) begin
        ptr <= '0;
        wrapped <= 1'b1;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vsll_level.sv @@
`default_nettype none

module vsll_level (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       upd,
  input  wire vsll_pkg::cfg_t             cfg,
  input  wire logic [vsll_pkg::MV_W-1:0]  mv,
  input  wire logic [vsll_pkg::REQ_W-1:0] request,
  output vsll_pkg::lvl_res_t              res
);

  import vsll_pkg::*;

  logic [REQ_W-1:0] limit_reg, limit_next;
  logic [REQ_W-1:0] previous_request;
  logic [CC_W-1:0]  low_confirm_count, low_confirm_count_next;
  logic [CC_W-1:0]  high_confirm_count, high_confirm_count_next;
  logic [CNT_W-1:0] raise_pause, raise_pause_next, raise_dec;
  logic [CNT_W-1:0] lower_pause, lower_pause_next, lower_dec;
  logic [CNT_W-1:0] no_nominal_count, no_nominal_count_next, no_nominal_bump;
  logic [CNT_W-1:0] error_counter;
  logic [1:0]       cls;
  logic             step_up;
  logic             step_down;
  logic             err;
  logic [9:0]       sum_raw;

  always_comb begin
    if (mv < cfg.low_threshold_mv) begin
      cls = CLASS_LOW;
    end else if (mv > cfg.high_threshold_mv) begin
      cls = CLASS_HIGH;
    end else begin
      cls = CLASS_BAND;
    end

    raise_dec = (raise_pause != '0) ? raise_pause - CNT_W'(1) : raise_pause;
    lower_dec = (lower_pause != '0) ? lower_pause - CNT_W'(1) : lower_pause;
    no_nominal_bump = (no_nominal_count < cfg.max_no_nominal) ?
                      no_nominal_count + CNT_W'(1) : no_nominal_count;

    low_confirm_count_next = low_confirm_count;
    high_confirm_count_next = high_confirm_count;
    raise_pause_next = raise_dec;
    lower_pause_next = lower_dec;
    no_nominal_count_next = no_nominal_count;
    step_up = 1'b0;
    step_down = 1'b0;

    case (cls)
      CLASS_LOW: begin
        high_confirm_count_next = cfg.confirm_cycles;
        low_confirm_count_next = (low_confirm_count != '0) ?
                                 low_confirm_count - CC_W'(1) : low_confirm_count;
        if (low_confirm_count_next == '0 && raise_dec == '0 &&
            limit_reg < cfg.limit_ceiling) begin
          raise_pause_next = cfg.pause_down_init;
          lower_pause_next = cfg.pause_up_after_low;
          step_up = 1'b1;
        end
        no_nominal_count_next = no_nominal_bump;
      end
      CLASS_HIGH: begin
        low_confirm_count_next = cfg.confirm_cycles;
        high_confirm_count_next = (high_confirm_count != '0) ?
                                  high_confirm_count - CC_W'(1) : high_confirm_count;
        if (high_confirm_count_next == '0) begin
          no_nominal_count_next = '0;
          if (lower_dec == '0 && limit_reg != '0) begin
            raise_pause_next = cfg.pause_down_init;
            lower_pause_next = cfg.pause_up_after_high;
            step_down = 1'b1;
          end
        end else begin
          no_nominal_count_next = no_nominal_bump;
        end
      end
      default: begin
        low_confirm_count_next = cfg.confirm_cycles;
        high_confirm_count_next = cfg.confirm_cycles;
        no_nominal_count_next = no_nominal_bump;
      end
    endcase

    // Two's complement sum; the top bit marks a negative result.
    sum_raw = 10'(limit_reg) + 10'(request) + 10'(step_up)
            - 10'(step_down) - 10'(previous_request);
    if (sum_raw[9]) begin
      limit_next = '0;
    end else if (sum_raw[8:0] > 9'(cfg.limit_ceiling)) begin
      limit_next = cfg.limit_ceiling;
    end else begin
      limit_next = sum_raw[REQ_W-1:0];
    end

    err = (no_nominal_count_next >= cfg.max_no_nominal);

    res.level_class = cls;
    res.curr_limit = limit_next;
    res.limit_moved = (limit_next != limit_reg);
    res.no_nominal_error = err;
    res.error_total = err ? error_counter + CNT_W'(1) : error_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= '0;
      previous_request <= RST_LIMIT_CEILING;
      low_confirm_count <= RST_CONFIRM_CYCLES;
      high_confirm_count <= RST_CONFIRM_CYCLES;
      raise_pause <= '0;
      lower_pause <= '0;
      no_nominal_count <= '0;
      error_counter <= '0;
    end else if (upd) begin
      limit_reg <= limit_next;
      low_confirm_count <= low_confirm_count_next;
      high_confirm_count <= high_confirm_count_next;
      raise_pause <= raise_pause_next;
      lower_pause <= lower_pause_next;
      no_nominal_count <= no_nominal_count_next;
      error_counter <= res.error_total;
      if (!err) begin
        previous_request <= request;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/voltage_sag_load_limiter.sv @@
// A transaction accepted in the idle state runs through S_SUM, S_MA to S_MF and S_LVL; its result
// enters the output register when S_LVL fires, which a stalled output holds off. The input is taken
// again only back in idle. The single shared multiplier forms six products in turn.
// Reset (rst, synchronous) clears the sequencer, the averaging ring, the counters and the output
// valid flag, and loads every configuration register with its default value.
`default_nettype none

module voltage_sag_load_limiter #(
  parameter int AVG_DEPTH = 16,
  parameter int VREF_MV = 3300,
  parameter int DIVIDER_RATIO = 11
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire vsll_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output vsll_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [vsll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vsll_pkg::CFG_DATA_W-1:0] cfg_data
);

  import vsll_pkg::*;

  localparam int SUM_W = ADC_W + $clog2(AVG_DEPTH);
  localparam int VREF_W = $clog2(VREF_MV + 1);
  localparam int DIV_W = $clog2(DIVIDER_RATIO + 1);
  localparam int D_W = $clog2(AVG_DEPTH + 1);
  localparam int P_W = ADC_W + VREF_W;
  localparam longint M1 = (longint'(1) << SUM_W) / AVG_DEPTH;
  localparam int M1_W = SUM_W + 1;
  localparam longint M2 = (longint'(1) << P_W) / ADC_FULL_SCALE;
  localparam int M2_W = $clog2(M2 + 1);
  localparam int A_W = (SUM_W > P_W) ? SUM_W : P_W;
  localparam int B0_W = (M1_W > M2_W) ? M1_W : M2_W;
  localparam int B1_W = (B0_W > VREF_W) ? B0_W : VREF_W;
  localparam int B2_W = (B1_W > ADC_W) ? B1_W : ADC_W;
  localparam int B3_W = (B2_W > DIV_W) ? B2_W : DIV_W;
  localparam int B_W = (B3_W > D_W) ? B3_W : D_W;
  localparam int PR_W = A_W + B_W;
  localparam int Q_W = (ADC_W > VREF_W) ? ADC_W : VREF_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SUM  = 9'b000000010,
    S_MA   = 9'b000000100,
    S_MB   = 9'b000001000,
    S_MC   = 9'b000010000,
    S_MD   = 9'b000100000,
    S_ME   = 9'b001000000,
    S_MF   = 9'b010000000,
    S_LVL  = 9'b100000000
  } state_t;

  state_t           state, state_next;
  cfg_t             cfg;
  logic [ADC_W-1:0] sample_q;
  logic [REQ_W-1:0] request_q;
  logic [SUM_W-1:0] sum;
  logic [A_W-1:0]   mul_a;
  logic [B_W-1:0]   mul_b;
  logic [PR_W-1:0]  prod;
  logic [Q_W-1:0]   qest, qest_next;
  logic [P_W-1:0]   scaled, scaled_next;
  logic [SUM_W-1:0] rem1;
  logic [P_W-1:0]   rem2;
  logic [ADC_W-1:0] avg;
  logic [VREF_W-1:0] quot2;
  logic             in_fire;
  logic             lvl_fire;
  lvl_res_t         lvl_res;

  assign in_stall = (state != S_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign lvl_fire = (state == S_LVL) && (!out_valid || !out_stall);

  vsll_ring #(
    .AVG_DEPTH(AVG_DEPTH),
    .SUM_W(SUM_W)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .wr(state == S_SUM),
    .sample(sample_q),
    .sum(sum)
  );

  vsll_mul #(
    .A_W(A_W),
    .B_W(B_W)
  ) u_mul (
    .clk(clk),
    .a(mul_a),
    .b(mul_b),
    .p(prod)
  );

  vsll_level u_level (
    .clk(clk),
    .rst(rst),
    .upd(lvl_fire),
    .cfg(cfg),
    .mv(prod[MV_W-1:0]),
    .request(request_q),
    .res(lvl_res)
  );

  // Both divisions use a reciprocal product, then one compare and add to correct the quotient.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    qest_next = qest;
    scaled_next = scaled;
    rem1 = sum - prod[SUM_W-1:0];
    rem2 = scaled - prod[P_W-1:0];
    avg = qest[ADC_W-1:0] + ADC_W'(rem1 >= SUM_W'(AVG_DEPTH));
    quot2 = qest[VREF_W-1:0] + VREF_W'(rem2 >= P_W'(ADC_FULL_SCALE));
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_MA;
      end
      S_MA: begin
        mul_a = A_W'(sum);
        mul_b = B_W'(M1);
        state_next = S_MB;
      end
      S_MB: begin
        qest_next = Q_W'(prod[SUM_W +: ADC_W]);
        mul_a = A_W'(prod[SUM_W +: ADC_W]);
        mul_b = B_W'(AVG_DEPTH);
        state_next = S_MC;
      end
      S_MC: begin
        mul_a = A_W'(avg);
        mul_b = B_W'(VREF_MV);
        state_next = S_MD;
      end
      S_MD: begin
        scaled_next = prod[P_W-1:0];
        mul_a = A_W'(prod[P_W-1:0]);
        mul_b = B_W'(M2);
        state_next = S_ME;
      end
      S_ME: begin
        qest_next = Q_W'(prod[P_W +: VREF_W]);
        mul_a = A_W'(prod[P_W +: VREF_W]);
        mul_b = B_W'(ADC_FULL_SCALE);
        state_next = S_MF;
      end
      S_MF: begin
        mul_a = A_W'(quot2);
        mul_b = B_W'(DIVIDER_RATIO);
        state_next = S_LVL;
      end
      S_LVL: begin
        // The millivolt value is passed through unchanged so that it holds while the
        // output register is stalled.
        mul_a = A_W'(prod[MV_W-1:0]);
        mul_b = B_W'(1);
        if (lvl_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    qest <= qest_next;
    scaled <= scaled_next;
    if (in_fire) begin
      sample_q <= in_data.adc_sample;
      request_q <= in_data.required_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold_mv <= RST_LOW_THRESHOLD;
      cfg.high_threshold_mv <= RST_HIGH_THRESHOLD;
      cfg.limit_ceiling <= RST_LIMIT_CEILING;
      cfg.confirm_cycles <= RST_CONFIRM_CYCLES;
      cfg.pause_down_init <= RST_PAUSE_DOWN_INIT;
      cfg.pause_up_after_low <= RST_PAUSE_UP_LOW;
      cfg.pause_up_after_high <= RST_PAUSE_UP_HIGH;
      cfg.max_no_nominal <= RST_MAX_NO_NOMINAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_THRESHOLD: cfg.low_threshold_mv <= cfg_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold_mv <= cfg_data;
        REG_LIMIT_CEILING: cfg.limit_ceiling <= cfg_data[REQ_W-1:0];
        REG_CONFIRM_CYCLES: cfg.confirm_cycles <= cfg_data[CC_W-1:0];
        REG_PAUSE_DOWN_INIT: cfg.pause_down_init <= cfg_data;
        REG_PAUSE_UP_LOW: cfg.pause_up_after_low <= cfg_data;
        REG_PAUSE_UP_HIGH: cfg.pause_up_after_high <= cfg_data;
        REG_MAX_NO_NOMINAL: cfg.max_no_nominal <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lvl_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_fire) begin
      out_data.filtered_mv <= prod[MV_W-1:0];
      out_data.level_class <= lvl_res.level_class;
      out_data.curr_limit <= lvl_res.curr_limit;
      out_data.limit_moved <= lvl_res.limit_moved;
      out_data.no_nominal_error <= lvl_res.no_nominal_error;
      out_data.error_total <= lvl_res.error_total;
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_SUM)
    else $error("accepted transaction did not start the ring update");

  a_result_from_level: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_LVL))
    else $error("output became valid without a level update");

  a_avg_remainder: assert property (@(posedge clk) disable iff (rst)
    state == S_MC |-> rem1 < SUM_W'(2 * AVG_DEPTH))
    else $error("average quotient estimate off by more than one");

  a_scale_remainder: assert property (@(posedge clk) disable iff (rst)
    state == S_MF |-> rem2 < P_W'(2 * ADC_FULL_SCALE))
    else $error("scaling quotient estimate off by more than one");

endmodule

`default_nettype wire

@@ tb/vsll_check.sv @@
`timescale 1ns / 1ps

module vsll_check #(
  parameter int AVG_DEPTH = 16,
  parameter int VREF_MV = 3300,
  parameter int DIVIDER_RATIO = 11
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input vsll_pkg::in_item_t in_data,
  input logic out_valid,
  input logic out_stall,
  input vsll_pkg::out_item_t out_data,
  input logic cfg_we,
  input logic [vsll_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [vsll_pkg::CFG_DATA_W-1:0] cfg_data,
  output int pending,
  output int fail_count
);

  import vsll_pkg::*;

  localparam int SUM_W = ADC_W + $clog2(AVG_DEPTH);

  cfg_t settings;
  logic [ADC_W-1:0] ring [AVG_DEPTH];
  int unsigned ring_pos;
  logic [SUM_W-1:0] ring_sum;
  logic [REQ_W-1:0] limit_now;
  logic [REQ_W-1:0] last_request;
  logic [CC_W-1:0] low_streak;
  logic [CC_W-1:0] high_streak;
  logic [CNT_W-1:0] raise_hold;
  logic [CNT_W-1:0] lower_hold;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] error_tally;
  out_item_t pending_limits [$];
  out_item_t want;
  int waiting = 0;
  int mismatches = 0;

  assign pending = waiting;
  assign fail_count = mismatches;

  function automatic out_item_t predict_limit_step(input in_item_t item);
    out_item_t res;
    int unsigned scaled;
    int target;
    logic count_miss;
    logic [REQ_W-1:0] old_limit;
    ring_sum = ring_sum - ring[ring_pos] + item.adc_sample;
    ring[ring_pos] = item.adc_sample;
    ring_pos = (ring_pos + 1) % AVG_DEPTH;
    scaled = ((ring_sum / AVG_DEPTH) * VREF_MV / ADC_FULL_SCALE) * DIVIDER_RATIO;
    res.filtered_mv = MV_W'(scaled);

    // The low test comes first, so overlapping thresholds read as low.
    if (res.filtered_mv < settings.low_threshold_mv) begin
      res.level_class = CLASS_LOW;
    end else if (res.filtered_mv > settings.high_threshold_mv) begin
      res.level_class = CLASS_HIGH;
    end else begin
      res.level_class = CLASS_BAND;
    end

    if (raise_hold != 0) raise_hold--;
    if (lower_hold != 0) lower_hold--;
    target = 0;
    count_miss = 1'b1;
    case (res.level_class)
      CLASS_LOW: begin
        high_streak = settings.confirm_cycles;
        if (low_streak != 0) low_streak--;
        if (low_streak == 0 && raise_hold == 0 && limit_now < settings.limit_ceiling) begin
          raise_hold = settings.pause_down_init;
          lower_hold = settings.pause_up_after_low;
          target = 1;
        end
      end
      CLASS_HIGH: begin
        low_streak = settings.confirm_cycles;
        if (high_streak != 0) high_streak--;
        if (high_streak == 0) begin
          count_miss = 1'b0;
          miss_count = '0;
          if (lower_hold == 0 && limit_now != 0) begin
            raise_hold = settings.pause_down_init;
            lower_hold = settings.pause_up_after_high;
            target = -1;
          end
        end
      end
      default: begin
        low_streak = settings.confirm_cycles;
        high_streak = settings.confirm_cycles;
      end
    endcase
    if (count_miss && miss_count < settings.max_no_nominal) miss_count++;

    old_limit = limit_now;
    target = target + int'(limit_now) + int'(item.required_step) - int'(last_request);
    if (target < 0) target = 0;
    if (target > int'(settings.limit_ceiling)) target = int'(settings.limit_ceiling);
    limit_now = REQ_W'(target);
    res.curr_limit = limit_now;
    res.limit_moved = (limit_now != old_limit);

    // On an error step the request is not remembered.
    res.no_nominal_error = (miss_count >= settings.max_no_nominal);
    if (res.no_nominal_error) begin
      error_tally++;
    end else begin
      last_request = item.required_step;
    end
    res.error_total = error_tally;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [CNT_W-1:0] expected,
                               input logic [CNT_W-1:0] actual);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings = '{RST_LOW_THRESHOLD, RST_HIGH_THRESHOLD, RST_LIMIT_CEILING,
                   RST_CONFIRM_CYCLES, RST_PAUSE_DOWN_INIT, RST_PAUSE_UP_LOW,
                   RST_PAUSE_UP_HIGH, RST_MAX_NO_NOMINAL};
      for (int i = 0; i < AVG_DEPTH; i++) ring[i] = '0;
      ring_pos = 0;
      ring_sum = '0;
      limit_now = '0;
      last_request = RST_LIMIT_CEILING;
      low_streak = RST_CONFIRM_CYCLES;
      high_streak = RST_CONFIRM_CYCLES;
      raise_hold = '0;
      lower_hold = '0;
      miss_count = '0;
      error_tally = '0;
      pending_limits.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_limits.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = pending_limits.pop_front();
          if (out_data.filtered_mv !== want.filtered_mv)
            flag_mismatch("filtered_mv", want.filtered_mv, out_data.filtered_mv);
          if (out_data.level_class !== want.level_class)
            flag_mismatch("level_class", want.level_class, out_data.level_class);
          if (out_data.curr_limit !== want.curr_limit)
            flag_mismatch("curr_limit", want.curr_limit, out_data.curr_limit);
          if (out_data.limit_moved !== want.limit_moved)
            flag_mismatch("limit_moved", want.limit_moved, out_data.limit_moved);
          if (out_data.no_nominal_error !== want.no_nominal_error)
            flag_mismatch("no_nominal_error", want.no_nominal_error, out_data.no_nominal_error);
          if (out_data.error_total !== want.error_total)
            flag_mismatch("error_total", want.error_total, out_data.error_total);
        end
      end
      if (in_valid && !in_stall) pending_limits.push_back(predict_limit_step(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_THRESHOLD: settings.low_threshold_mv = cfg_data[MV_W-1:0];
          REG_HIGH_THRESHOLD: settings.high_threshold_mv = cfg_data[MV_W-1:0];
          REG_LIMIT_CEILING: settings.limit_ceiling = cfg_data[REQ_W-1:0];
          REG_CONFIRM_CYCLES: settings.confirm_cycles = cfg_data[CC_W-1:0];
          REG_PAUSE_DOWN_INIT: settings.pause_down_init = cfg_data[CNT_W-1:0];
          REG_PAUSE_UP_LOW: settings.pause_up_after_low = cfg_data[CNT_W-1:0];
          REG_PAUSE_UP_HIGH: settings.pause_up_after_high = cfg_data[CNT_W-1:0];
          REG_MAX_NO_NOMINAL: settings.max_no_nominal = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    waiting <= pending_limits.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import vsll_pkg::*;

  localparam int AVG_DEPTH = 16;
  localparam int VREF_MV = 3300;
  localparam int DIVIDER_RATIO = 11;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int pending;
  int fail_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  logic [MV_W-1:0] cur_low = RST_LOW_THRESHOLD;
  logic [MV_W-1:0] cur_high = RST_HIGH_THRESHOLD;
  logic [REQ_W-1:0] cur_max = RST_LIMIT_CEILING;

  voltage_sag_load_limiter #(
    .AVG_DEPTH(AVG_DEPTH),
    .VREF_MV(VREF_MV),
    .DIVIDER_RATIO(DIVIDER_RATIO)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  vsll_check #(
    .AVG_DEPTH(AVG_DEPTH),
    .VREF_MV(VREF_MV),
    .DIVIDER_RATIO(DIVIDER_RATIO)
  ) limit_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending),
    .fail_count(fail_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // A long hold-off is counted here so that the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_started != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      holds_started <= holds_started + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_sample(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_settings(input int lo, input int hi, input int mx, input int cf,
                               input int pd, input int pl, input int pu, input int nn);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_LIMIT_CEILING, mx);
    write_reg(REG_CONFIRM_CYCLES, cf);
    write_reg(REG_PAUSE_DOWN_INIT, pd);
    write_reg(REG_PAUSE_UP_LOW, pl);
    write_reg(REG_PAUSE_UP_HIGH, pu);
    write_reg(REG_MAX_NO_NOMINAL, nn);
    cfg_we <= 1'b0;
    cur_low = MV_W'(lo);
    cur_high = MV_W'(hi);
    cur_max = REQ_W'(mx);
  endtask

  // Samples come in bursts around one level, many of them near a threshold, so that
  // levels get confirmed and the pause timers come into play; a few are pure noise.
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    int level;
    int left;
    int req;
    int s;
    int pick;
    in_item_t item;
    left = 0;
    level = 0;
    req = $urandom_range(127);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_requests <= hold_requests + 1;
      if (k == pause_at) drain_results();
      if (left == 0) begin
        left = $urandom_range(40, 3);
        if ($urandom_range(99) < 45) begin
          level = ($urandom_range(1) ? int'(cur_low) : int'(cur_high)) * ADC_FULL_SCALE
                  / (VREF_MV * DIVIDER_RATIO) + int'($urandom_range(80)) - 40;
        end else begin
          level = $urandom_range(ADC_FULL_SCALE);
        end
      end
      left--;
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(ADC_FULL_SCALE);
      end else begin
        s = level + int'($urandom_range(16)) - 8;
      end
      if (s < 0) s = 0;
      if (s > ADC_FULL_SCALE) s = ADC_FULL_SCALE;
      pick = $urandom_range(99);
      if (pick < 70) begin
        req = req + int'($urandom_range(4)) - 2;
      end else if (pick < 85) begin
        req = $urandom_range(int'(cur_max));
      end else begin
        req = $urandom_range(127);
      end
      if (req < 0) req = 0;
      if (req > 127) req = 127;
      item.adc_sample = ADC_W'(s);
      item.required_step = REQ_W'(req);
      send_sample(item);
    end
  endtask

  initial begin
    int lo;
    int hi;
    int mx;
    int cf;
    int pd;
    int pl;
    int pu;
    int nn;
    in_item_t item;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Default settings: the average climbs from low through the band into high.
    for (int k = 0; k < 12; k++) begin
      item.adc_sample = (k == 0) ? '0 : '1;
      item.required_step = (k == 1) ? '0 : REQ_W'(127 - 9 * k);
      send_sample(item);
    end

    // Overlapping thresholds, immediate confirmation and an error on every step.
    drain_results();
    load_settings(65535, 0, 127, 0, 0, 0, 0, 0);
    item = '{adc_sample: 12'd4095, required_step: 7'd0};
    send_sample(item);
    item = '{adc_sample: 12'd0, required_step: 7'd64};
    send_sample(item);
    item = '{adc_sample: 12'd1, required_step: 7'd1};
    send_sample(item);
    item = '{adc_sample: 12'd2048, required_step: 7'd127};
    send_sample(item);

    // Everything reads high; the lowered bound pulls the limit down at once.
    drain_results();
    load_settings(0, 0, 2, 0, 0, 0, 0, 3);
    for (int k = 0; k < 4; k++) begin
      item.adc_sample = ADC_W'(ADC_FULL_SCALE - k);
      item.required_step = REQ_W'(k);
      send_sample(item);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      lo = 9500 + $urandom_range(2500);
      if ($urandom_range(9) == 0) begin
        hi = lo - int'($urandom_range(1000));
      end else begin
        hi = lo + int'($urandom_range(3000));
      end
      mx = $urandom_range(127, 1);
      cf = $urandom_range(6);
      pd = $urandom_range(30);
      pl = $urandom_range(60);
      pu = $urandom_range(40);
      nn = $urandom_range(40, 1);
      case (ph)
        1: begin
          mx = 127;
          cf = 0;
          pd = 0;
          pl = 0;
          pu = 0;
        end
        2: mx = 0;
        3: begin
          cf = 255;
          pd = 65535;
          pl = 65535;
          pu = 65535;
          nn = 65535;
        end
        4: begin
          lo = 0;
          hi = 65535;
        end
        5: begin
          lo = 65535;
          hi = 65535;
        end
        6: begin
          lo = 0;
          hi = 0;
        end
        default: ;
      endcase
      load_settings(lo, hi, mx, cf, pd, pl, pu, nn);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 58;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 58;
        end
        default: begin
          idle_pct = 38;
          stall_pct <= 38;
        end
      endcase
      run_random(PHASE_ITEMS, (ph == 0) ? 50 : -1, (ph == 4) ? 60 : -1);
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
